// ===== sv/mtb_pkg.sv =====
// mtb_pkg: shared constants, lane control struct and arithmetic helpers
// for the morph target blend core; no dependencies
package mtb_pkg;

    localparam int COORD_W    = 32;
    localparam int SUM_W      = 40;
    localparam int CNT_W      = 7;
    localparam int RATE_W     = 17;
    localparam int MAX_POSES  = 64;
    localparam int DIV_STEPS  = SUM_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = DIFF_W + RATE_W + 1;
    localparam int WIDE_W     = PROD_W + 1;
    localparam int REM_W      = CNT_W + 1;
    localparam int NUM_LANES  = 3;
    localparam int CFG_IDX_W  = 1;

    localparam logic [RATE_W-1:0] ONE_Q16 = RATE_W'(65536);
    localparam logic [CNT_W-1:0]  MAX_CNT = CNT_W'(MAX_POSES);

    localparam logic [CFG_IDX_W-1:0] REG_ON_KEY_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_KEY_W = 1'd1;

    typedef struct packed {
        logic item_load;
        logic mul;
        logic acc1;
        logic acc2;
        logic div_load;
        logic div_step;
        logic avg;
        logic mix_load;
        logic clear;
    } lane_ctl_t;

    function automatic logic [RATE_W-1:0] sat_rate(input logic [RATE_W-1:0] r);
        return (r > ONE_Q16) ? ONE_Q16 : r;
    endfunction

    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
        lo = -hi - WIDE_W'(1);
        if (v > hi)
            return hi[COORD_W-1:0];
        else if (v < lo)
            return lo[COORD_W-1:0];
        else
            return v[COORD_W-1:0];
    endfunction

endpackage

// ===== sv/mtb_lane.sv =====
// mtb_lane: one coordinate axis; blend multipliers, per-key sums and
// serial dividers for the averages; depends on mtb_pkg
module mtb_lane import mtb_pkg::*; (
    input  logic                       clk,
    input  logic                       rst_n,
    input  lane_ctl_t                  ctl,
    input  logic signed [COORD_W-1:0]  rest,
    input  logic signed [COORD_W-1:0]  target,
    input  logic [RATE_W-1:0]          rate1,
    input  logic [RATE_W-1:0]          rate2,
    input  logic [RATE_W-1:0]          weight,
    input  logic [CNT_W-1:0]           cnt1,
    input  logic [CNT_W-1:0]           cnt2,
    output logic signed [COORD_W-1:0]  avg1,
    output logic signed [COORD_W-1:0]  blend1
);

    logic signed [COORD_W-1:0] opa1_reg, opb1_reg, opa2_reg, opb2_reg;
    logic [RATE_W-1:0]         w1_reg, w2_reg;
    logic signed [PROD_W-1:0]  prod1_reg, prod2_reg;
    logic signed [SUM_W-1:0]   sum1_reg, sum2_reg;
    logic [SUM_W-1:0]          num1_reg, num2_reg;
    logic [REM_W-1:0]          rem1_reg, rem2_reg;
    logic                      neg1_reg, neg2_reg;
    logic signed [COORD_W-1:0] avg1_reg, avg2_reg;

    logic signed [COORD_W-1:0] blend2;
    logic [REM_W-1:0]          rsh1, rsh2, rnx1, rnx2;
    logic                      qb1, qb2;

    function automatic logic signed [COORD_W-1:0] blend_out(
        input logic signed [PROD_W-1:0] p, input logic signed [COORD_W-1:0] b);
        logic signed [WIDE_W-1:0] t;
        t = ($signed({p[PROD_W-1], p}) + WIDE_W'(32768)) >>> 16;
        t = t + WIDE_W'(b);
        return sat_coord(t);
    endfunction

    function automatic logic signed [PROD_W-1:0] mult(
        input logic signed [COORD_W-1:0] a, input logic signed [COORD_W-1:0] b,
        input logic [RATE_W-1:0] w);
        logic signed [DIFF_W-1:0] d;
        d = DIFF_W'(a) - DIFF_W'(b);
        return d * $signed({1'b0, w});
    endfunction

    function automatic logic [SUM_W-1:0] div_num(
        input logic signed [SUM_W-1:0] s, input logic [CNT_W-1:0] c);
        logic [SUM_W-1:0] m;
        m = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
        return m + SUM_W'(c >> 1);
    endfunction

    function automatic logic signed [COORD_W-1:0] avg_out(
        input logic [SUM_W-1:0] q, input logic neg);
        logic signed [WIDE_W-1:0] v;
        v = WIDE_W'(q);
        if (neg)
            v = -v;
        return sat_coord(v);
    endfunction

    assign blend1 = blend_out(prod1_reg, opb1_reg);
    assign blend2 = blend_out(prod2_reg, opb2_reg);
    assign avg1   = avg1_reg;

    assign rsh1 = {rem1_reg[REM_W-2:0], num1_reg[SUM_W-1]};
    assign rsh2 = {rem2_reg[REM_W-2:0], num2_reg[SUM_W-1]};
    assign qb1  = rsh1 >= {1'b0, cnt1};
    assign qb2  = rsh2 >= {1'b0, cnt2};
    assign rnx1 = qb1 ? rsh1 - {1'b0, cnt1} : rsh1;
    assign rnx2 = qb2 ? rsh2 - {1'b0, cnt2} : rsh2;

    always_ff @(posedge clk)
    begin
        if (ctl.item_load)
        begin
            opa1_reg <= target;
            opb1_reg <= rest;
            w1_reg   <= sat_rate(rate1);
            opa2_reg <= target;
            opb2_reg <= rest;
            w2_reg   <= sat_rate(rate2);
        end
        else if (ctl.mix_load)
        begin
            opa1_reg <= avg1_reg;
            opb1_reg <= avg2_reg;
            w1_reg   <= weight;
        end
        if (ctl.mul)
        begin
            prod1_reg <= mult(opa1_reg, opb1_reg, w1_reg);
            prod2_reg <= mult(opa2_reg, opb2_reg, w2_reg);
        end
        if (ctl.div_load)
        begin
            num1_reg <= div_num(sum1_reg, cnt1);
            num2_reg <= div_num(sum2_reg, cnt2);
            neg1_reg <= sum1_reg[SUM_W-1];
            neg2_reg <= sum2_reg[SUM_W-1];
            rem1_reg <= '0;
            rem2_reg <= '0;
        end
        else if (ctl.div_step)
        begin
            num1_reg <= {num1_reg[SUM_W-2:0], qb1};
            num2_reg <= {num2_reg[SUM_W-2:0], qb2};
            rem1_reg <= rnx1;
            rem2_reg <= rnx2;
        end
        if (ctl.avg)
        begin
            avg1_reg <= avg_out(num1_reg, neg1_reg);
            avg2_reg <= avg_out(num2_reg, neg2_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum1_reg <= '0;
            sum2_reg <= '0;
        end
        else if (ctl.clear)
        begin
            sum1_reg <= '0;
            sum2_reg <= '0;
        end
        else
        begin
            if (ctl.acc1)
                sum1_reg <= sum1_reg + SUM_W'(blend1);
            if (ctl.acc2)
                sum2_reg <= sum2_reg + SUM_W'(blend2);
        end
    end

endmodule

// ===== sv/morph_target_blend_core.sv =====
// morph_target_blend_core: top level; three axis lanes, sequencer, pose
// counts and the merging output stage; depends on mtb_pkg and mtb_lane
// sequence: a pose item passes the multiply and accumulate states; a last pose item then runs
// the 40-step serial divider, the average and the key mix multiply before its result is valid
// input: stalled while busy; a new item is taken only in idle, after any result has been taken
// reset: mode on-key off, first key weight one, sums and counts cleared
module morph_target_blend_core import mtb_pkg::*; (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [RATE_W-1:0]          cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [COORD_W-1:0]  rest_x,
    input  logic signed [COORD_W-1:0]  rest_y,
    input  logic signed [COORD_W-1:0]  rest_z,
    input  logic signed [COORD_W-1:0]  target_x,
    input  logic signed [COORD_W-1:0]  target_y,
    input  logic signed [COORD_W-1:0]  target_z,
    input  logic                       target_present,
    input  logic                       first_key_on,
    input  logic [RATE_W-1:0]          first_key_rate,
    input  logic                       second_key_on,
    input  logic [RATE_W-1:0]          second_key_rate,
    input  logic                       last_pose,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [COORD_W-1:0]  out_x,
    output logic signed [COORD_W-1:0]  out_y,
    output logic signed [COORD_W-1:0]  out_z,
    output logic                       updated
);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_ACC, S_DIV_LOAD, S_DIV, S_AVG,
        S_MIX_LOAD, S_MIX_MUL, S_MIX, S_OUT
    } state_t;

    state_t                    state_reg;
    logic                      mode_reg;
    logic [RATE_W-1:0]         weight_reg;
    logic [CNT_W-1:0]          cnt1_reg, cnt2_reg;
    logic                      en1_reg, en2_reg, last_reg;
    logic [STEP_W-1:0]         step_reg;
    logic signed [COORD_W-1:0] res_reg [NUM_LANES];
    logic                      upd_reg;

    lane_ctl_t                 ctl;
    logic                      in_xfer, upd_next;
    logic signed [COORD_W-1:0] rest_a [NUM_LANES];
    logic signed [COORD_W-1:0] tgt_a  [NUM_LANES];
    logic signed [COORD_W-1:0] avg_a  [NUM_LANES];
    logic signed [COORD_W-1:0] mix_a  [NUM_LANES];

    assign rest_a = '{rest_x, rest_y, rest_z};
    assign tgt_a  = '{target_x, target_y, target_z};

    assign in_stall  = (state_reg != S_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_valid = (state_reg == S_OUT);
    assign out_x     = res_reg[0];
    assign out_y     = res_reg[1];
    assign out_z     = res_reg[2];
    assign updated   = upd_reg;

    assign upd_next = mode_reg ? (cnt1_reg != '0)
                               : (cnt1_reg != '0) && (cnt2_reg != '0);

    always_comb
    begin
        ctl           = '0;
        ctl.item_load = in_xfer;
        ctl.mul       = (state_reg == S_MUL) || (state_reg == S_MIX_MUL);
        ctl.acc1      = (state_reg == S_ACC) && en1_reg;
        ctl.acc2      = (state_reg == S_ACC) && en2_reg;
        ctl.div_load  = (state_reg == S_DIV_LOAD);
        ctl.div_step  = (state_reg == S_DIV);
        ctl.avg       = (state_reg == S_AVG);
        ctl.mix_load  = (state_reg == S_MIX_LOAD);
        ctl.clear     = (state_reg == S_MIX);
    end

    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        mtb_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctl    (ctl),
            .rest   (rest_a[g]),
            .target (tgt_a[g]),
            .rate1  (first_key_rate),
            .rate2  (second_key_rate),
            .weight (weight_reg),
            .cnt1   (cnt1_reg),
            .cnt2   (cnt2_reg),
            .avg1   (avg_a[g]),
            .blend1 (mix_a[g])
        );
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_MIX)
        begin
            for (int i = 0; i < NUM_LANES; i++)
                res_reg[i] <= !upd_next ? '0 : (mode_reg ? avg_a[i] : mix_a[i]);
            upd_reg <= upd_next;
        end
        if (in_xfer)
        begin
            en1_reg  <= target_present && first_key_on && (cnt1_reg < MAX_CNT);
            en2_reg  <= target_present && second_key_on && (cnt2_reg < MAX_CNT);
            last_reg <= last_pose;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            mode_reg   <= 1'b0;
            weight_reg <= ONE_Q16;
            cnt1_reg   <= '0;
            cnt2_reg   <= '0;
            step_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_ON_KEY_MODE: mode_reg   <= cfg_data[0];
                    REG_FIRST_KEY_W: weight_reg <= sat_rate(cfg_data);
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                    if (in_xfer)
                        state_reg <= S_MUL;
                S_MUL:
                    state_reg <= S_ACC;
                S_ACC:
                begin
                    if (en1_reg)
                        cnt1_reg <= cnt1_reg + CNT_W'(1);
                    if (en2_reg)
                        cnt2_reg <= cnt2_reg + CNT_W'(1);
                    state_reg <= last_reg ? S_DIV_LOAD : S_IDLE;
                end
                S_DIV_LOAD:
                begin
                    step_reg  <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(DIV_STEPS - 1))
                        state_reg <= S_AVG;
                end
                S_AVG:
                    state_reg <= S_MIX_LOAD;
                S_MIX_LOAD:
                    state_reg <= S_MIX_MUL;
                S_MIX_MUL:
                    state_reg <= S_MIX;
                S_MIX:
                begin
                    cnt1_reg  <= '0;
                    cnt2_reg  <= '0;
                    state_reg <= S_OUT;
                end
                S_OUT:
                    if (!out_stall)
                        state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
